@@ src/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    // One queued result group: one to four beats, bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      nlast;   // index of the final beat
        logic [3:0]      status;
    } t_cmd;

endpackage

@@ src/jsu_front.sv @@
// Front end: parses text bytes and queues UTF-8 byte groups or status beats.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_byte,
    input  logic          i_eot,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_BODY    = 3'd1;
    localparam logic [2:0] PH_ESC     = 3'd2;
    localparam logic [2:0] PH_HEX1    = 3'd3;
    localparam logic [2:0] PH_PAIR_BS = 3'd4;
    localparam logic [2:0] PH_PAIR_U  = 3'd5;
    localparam logic [2:0] PH_HEX2    = 3'd6;

    localparam logic [3:0] ST_BYTE       = 4'd0;
    localparam logic [3:0] ST_DONE       = 4'd1;
    localparam logic [3:0] ST_UNTERM     = 4'd2;
    localparam logic [3:0] ST_CTRL       = 4'd3;
    localparam logic [3:0] ST_OPEN_ESC   = 4'd4;
    localparam logic [3:0] ST_BAD_ESC    = 4'd5;
    localparam logic [3:0] ST_TRUNC_U    = 4'd6;
    localparam logic [3:0] ST_NONHEX     = 4'd7;
    localparam logic [3:0] ST_HI_UNPAIR  = 4'd8;
    localparam logic [3:0] ST_HI_NONLOW  = 4'd9;
    localparam logic [3:0] ST_LONE_LOW   = 4'd10;
    localparam logic [3:0] ST_NO_QUOTE   = 4'd11;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_high, n_high;
    logic [1:0]  r_cnt, n_cnt;

    function automatic jsu_pkg::t_cmd f_single(input logic [7:0] b, input logic [3:0] st);
        jsu_pkg::t_cmd c;
        c.bytes  = '0;
        c.bytes[0] = b;
        c.nlast  = 2'd0;
        c.status = st;
        return c;
    endfunction

    function automatic jsu_pkg::t_cmd f_utf8(input logic [20:0] cp);
        jsu_pkg::t_cmd c;
        c.bytes  = '0;
        c.status = ST_BYTE;
        if (cp < 21'h80) begin
            c.bytes[0] = cp[7:0];
            c.nlast    = 2'd0;
        end else if (cp < 21'h800) begin
            c.bytes[0] = {3'b110, cp[10:6]};
            c.bytes[1] = {2'b10, cp[5:0]};
            c.nlast    = 2'd1;
        end else if (cp < 21'h10000) begin
            c.bytes[0] = {4'b1110, cp[15:12]};
            c.bytes[1] = {2'b10, cp[11:6]};
            c.bytes[2] = {2'b10, cp[5:0]};
            c.nlast    = 2'd2;
        end else begin
            c.bytes[0] = {5'b11110, cp[20:18]};
            c.bytes[1] = {2'b10, cp[17:12]};
            c.bytes[2] = {2'b10, cp[11:6]};
            c.bytes[3] = {2'b10, cp[5:0]};
            c.nlast    = 2'd3;
        end
        return c;
    endfunction

    logic       w_is_hex;
    logic [3:0] w_digit;
    logic [15:0] w_unit;

    always_comb begin
        w_is_hex = 1'b1;
        w_digit  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_digit = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            w_digit = i_byte[3:0] + 4'd9;
        end else begin
            w_is_hex = 1'b0;
        end
    end

    assign w_unit = {r_acc[11:0], w_digit};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_high  = r_high;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_cmd   = f_single(8'h00, ST_BYTE);
        unique case (r_phase)
            PH_BODY: begin
                if (i_eot) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_UNTERM); n_phase = PH_IDLE;
                end else if (i_byte == 8'h22) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_DONE); n_phase = PH_IDLE;
                end else if (i_byte < 8'h20) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_CTRL); n_phase = PH_IDLE;
                end else if (i_byte == 8'h5C) begin
                    n_phase = PH_ESC;
                end else begin
                    o_push = 1'b1; o_cmd = f_single(i_byte, ST_BYTE);
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                o_push  = 1'b1;
                if (i_eot) begin
                    o_cmd = f_single(8'h00, ST_OPEN_ESC); n_phase = PH_IDLE;
                end else begin
                    case (i_byte)
                        8'h22, 8'h5C, 8'h2F: o_cmd = f_single(i_byte, ST_BYTE);
                        8'h62: o_cmd = f_single(8'h08, ST_BYTE);
                        8'h66: o_cmd = f_single(8'h0C, ST_BYTE);
                        8'h6E: o_cmd = f_single(8'h0A, ST_BYTE);
                        8'h72: o_cmd = f_single(8'h0D, ST_BYTE);
                        8'h74: o_cmd = f_single(8'h09, ST_BYTE);
                        8'h75: begin
                            o_push  = 1'b0;
                            n_phase = PH_HEX1;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end
                        default: begin
                            o_cmd = f_single(8'h00, ST_BAD_ESC); n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (i_eot) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_TRUNC_U); n_phase = PH_IDLE;
                end else if (!w_is_hex) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_NONHEX); n_phase = PH_IDLE;
                end else if (r_cnt != 2'd3) begin
                    n_acc = w_unit;
                    n_cnt = r_cnt + 2'd1;
                end else begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (r_phase == PH_HEX2) begin
                        o_push = 1'b1;
                        if (w_unit < 16'hDC00 || w_unit > 16'hDFFF) begin
                            o_cmd = f_single(8'h00, ST_HI_NONLOW); n_phase = PH_IDLE;
                        end else begin
                            o_cmd = f_utf8(21'h10000 + {1'b0, r_high[9:0], w_unit[9:0]});
                            n_phase = PH_BODY;
                        end
                    end else if (w_unit >= 16'hD800 && w_unit <= 16'hDBFF) begin
                        n_high  = w_unit;
                        n_phase = PH_PAIR_BS;
                    end else if (w_unit >= 16'hDC00 && w_unit <= 16'hDFFF) begin
                        o_push = 1'b1; o_cmd = f_single(8'h00, ST_LONE_LOW); n_phase = PH_IDLE;
                    end else begin
                        o_push = 1'b1; o_cmd = f_utf8({5'd0, w_unit}); n_phase = PH_BODY;
                    end
                end
            end
            PH_PAIR_BS: begin
                if (i_eot || i_byte != 8'h5C) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_HI_UNPAIR); n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_PAIR_U;
                end
            end
            PH_PAIR_U: begin
                if (i_eot || i_byte != 8'h75) begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_HI_UNPAIR); n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_HEX2;
                    n_acc   = '0;
                    n_cnt   = '0;
                end
            end
            default: begin
                if (!i_eot && i_byte == 8'h22) begin
                    n_phase = PH_BODY;
                    n_acc   = '0;
                    n_cnt   = '0;
                end else begin
                    o_push = 1'b1; o_cmd = f_single(8'h00, ST_NO_QUOTE); n_phase = PH_IDLE;
                end
            end
        endcase
        if (!i_fire) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_high  <= '0;
            r_cnt   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_high  <= n_high;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ src/jsu_fifo.sv @@
// Short queue of result groups between front and back ends.
module jsu_fifo #(
    parameter int DEPTH = jsu_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_data,
    input  logic          i_pop,
    output jsu_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (w_rd) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ src/jsu_back.sv @@
// Back end: unpacks queued result groups into output beats.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic [3:0]    o_status,
    output logic          o_last
);

    jsu_pkg::t_cmd r_cur;
    logic          r_have;
    logic [1:0]    r_idx;
    logic          w_load;

    assign o_valid  = r_have;
    assign o_byte   = r_cur.bytes[r_idx];
    assign o_status = r_cur.status;
    assign o_last   = (r_idx == r_cur.nlast);
    assign w_load   = !r_have || (i_ready && o_last);
    assign o_pop    = w_load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_have <= !i_empty;
            r_idx  <= '0;
        end else if (i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

@@ src/json_string_unescape_utf8.sv @@
// An accepted byte is queued, then registered in the back end, then output.
// Throughput: one text byte per cycle; a \u escape yields up to four beats,
// one per cycle, and the result queue (FIFO_DEPTH groups) absorbs the burst.
// Input stalls only when the queue is full; output beats wait for i_m_tready.
// Reset (i_rst_n low, synchronous) empties the queue and returns to idle.
// Top level: JSON string body unescaper producing UTF-8 bytes and status beats.
module json_string_unescape_utf8 #(
    parameter int FIFO_DEPTH = jsu_pkg::FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] text_byte
    input  logic       i_s_tuser,    // [0] end_of_text
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic [3:0] o_m_tuser,    // [3:0] status
    output logic       o_m_tlast
);

    jsu_pkg::t_cmd w_push_cmd, w_head;
    logic          w_push, w_pop, w_full, w_empty, w_fire;

    assign o_s_tready = !w_full;
    assign w_fire     = i_s_tvalid && o_s_tready;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (i_s_tdata),
        .i_eot   (i_s_tuser),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_byte   (o_m_tdata),
        .o_status (o_m_tuser),
        .o_last   (o_m_tlast)
    );

endmodule
